// ----- rtl/core/bucket_slot_allocator_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef BUCKET_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define BUCKET_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types, codes and helpers of the bucket slot allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int NUM_SLOTS   = 16;
  localparam int BKT_W       = 4;
  localparam int SLT_W       = 4;
  localparam int ADDR_W      = BKT_W + SLT_W;
  localparam int ENTRY_W     = 10;
  localparam int ID_W        = 32;

  localparam logic [ENTRY_W-1:0] MARK_EMPTY   = 10'h3FF;
  localparam logic [ENTRY_W-1:0] MARK_REMOVED = 10'h3FE;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOCATE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SLOT   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_FLAGS = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  object_index;
    logic [31:0] object_id;
    logic        allow_new_bucket;
    logic        prefer_new_bucket;
    logic        batch_start;
    logic        strict_remove;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  placed_index;
    logic [3:0]  placed_bucket;
    logic [3:0]  placed_slot;
    logic [31:0] found_id;
    logic        bucket_dropped;
    logic [3:0]  dropped_bucket;
    logic [8:0]  free_slots;
    logic [8:0]  object_total;
    logic [4:0]  bucket_total;
    logic        table_valid;
  } result_t;

  // capacity clamped to 1..NUM_SLOTS
  function automatic logic [4:0] eff_cap(input logic [4:0] c);
    logic [4:0] r;
    r = c;
    if (c == 5'd0) r = 5'd1;
    if (c > 5'(NUM_SLOTS)) r = 5'(NUM_SLOTS);
    return r;
  endfunction

endpackage

// ----- rtl/core/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bsa_engine.sv -----
// ----------------------------------------------------------------------------
// bsa_engine
// sequencer with one address walker and compare unit over the slot table
// ----------------------------------------------------------------------------
module bsa_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bsa_pkg::item_t    item,
  input  logic [4:0]        cap,
  input  logic              take,
  output logic              ready,
  output logic              done,
  output bsa_pkg::result_t  res
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_ADD_SCAN  = 4'd2;
  localparam logic [3:0] S_ADD_NEW   = 4'd3;
  localparam logic [3:0] S_ADD_OPEN  = 4'd4;
  localparam logic [3:0] S_ADD_FRESH = 4'd5;
  localparam logic [3:0] S_ADD_WRITE = 4'd6;
  localparam logic [3:0] S_FIND      = 4'd7;
  localparam logic [3:0] S_ID_WAIT   = 4'd8;
  localparam logic [3:0] S_LIVE      = 4'd9;
  localparam logic [3:0] S_COPY      = 4'd10;
  localparam logic [3:0] S_WIPE      = 4'd11;
  localparam logic [3:0] S_POST      = 4'd12;
  localparam logic [3:0] S_DEC       = 4'd13;
  localparam logic [3:0] S_SHIFT     = 4'd14;
  localparam logic [3:0] S_DONE      = 4'd15;

  localparam logic [3:0] SLT_LAST = 4'hF;

  logic [3:0] state, state_next;
  logic [3:0] bkt, bkt_next, slt, slt_next, wrap, wrap_next;
  logic [7:0] last_addr, last_addr_next;
  logic       go, go_next;
  logic       rd_v, rd_v_next;
  logic [7:0] rd_a, rd_a_next;
  logic [4:0] used, used_next;
  logic [8:0] live, live_next, occ, occ_next;
  logic       ok, ok_next;
  logic [4:0] open_nb, open_nb_next, open_sel, open_sel_next;
  bsa_pkg::item_t   cur, cur_next;
  bsa_pkg::result_t res_q, res_q_next;
  logic [3:0] tgt_b, tgt_b_next, tgt_s, tgt_s_next;
  logic       live_seen, live_seen_next;
  logic [4:0] used_cnt, used_cnt_next;

  logic                          t_we, t_re;
  logic [7:0]                    t_waddr, t_raddr;
  logic [bsa_pkg::ENTRY_W-1:0]   t_wdata, t_rdata;
  logic                          i_we, i_re;
  logic [7:0]                    i_waddr, i_raddr;
  logic [bsa_pkg::ID_W-1:0]      i_wdata, i_rdata;

  logic [7:0] at;
  logic       at_last;
  logic [3:0] step_bkt, step_slt;
  logic [3:0] used_m1, cap_m1;
  logic [4:0] open_m1, onb_m1;
  logic [8:0] idx_p1, live_m1;
  logic [9:0] prod;

  bsa_ram #(.ADDR_W(bsa_pkg::ADDR_W), .DATA_W(bsa_pkg::ENTRY_W)) u_slot_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  bsa_ram #(.ADDR_W(bsa_pkg::ADDR_W), .DATA_W(bsa_pkg::ID_W)) u_id_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .re(i_re), .raddr(i_raddr), .rdata(i_rdata)
  );

  // walker: next address within the current range
  assign at      = {bkt, slt};
  assign at_last = (at == last_addr);
  always_comb begin
    if (slt == wrap) begin
      step_bkt = bkt + 4'd1;
      step_slt = 4'd0;
    end else begin
      step_bkt = bkt;
      step_slt = slt + 4'd1;
    end
  end

  assign used_m1 = used[3:0] - 4'd1;
  assign cap_m1  = cap[3:0] - 4'd1;
  assign open_m1 = open_sel - 5'd1;
  assign onb_m1  = open_nb - 5'd1;
  assign idx_p1  = {1'b0, cur.object_index} + 9'd1;
  assign live_m1 = live - 9'd1;

  always_comb begin
    state_next     = state;
    bkt_next       = bkt;
    slt_next       = slt;
    wrap_next      = wrap;
    last_addr_next = last_addr;
    go_next        = go;
    rd_v_next      = 1'b0;
    rd_a_next      = at;
    used_next      = used;
    live_next      = live;
    occ_next       = occ;
    ok_next        = ok;
    open_nb_next   = open_nb;
    open_sel_next  = open_sel;
    cur_next       = cur;
    res_q_next     = res_q;
    tgt_b_next     = tgt_b;
    tgt_s_next     = tgt_s;
    live_seen_next = live_seen;
    used_cnt_next  = used_cnt;
    t_we    = 1'b0;
    t_waddr = at;
    t_wdata = bsa_pkg::MARK_EMPTY;
    t_re    = 1'b0;
    t_raddr = at;
    i_we    = 1'b0;
    i_waddr = rd_a;
    i_wdata = i_rdata;
    i_re    = 1'b0;
    i_raddr = at;

    unique case (state)
      S_CLEAR: begin
        t_we = 1'b1;
        if (at_last) begin
          go_next    = 1'b0;
          state_next = S_IDLE;
        end else begin
          bkt_next = step_bkt;
          slt_next = step_slt;
        end
      end

      S_IDLE: begin
        if (start) begin
          cur_next       = item;
          res_q_next     = '0;
          open_sel_next  = item.batch_start ? 5'd0 : open_nb;
          bkt_next       = 4'd0;
          slt_next       = 4'd0;
          last_addr_next = {used_m1, SLT_LAST};
          wrap_next      = SLT_LAST;
          go_next        = (used != 5'd0);
          if (!ok) begin
            res_q_next.status = bsa_pkg::ST_INVALID;
            state_next        = S_DONE;
          end else begin
            unique case (item.action)
              bsa_pkg::ACT_ADD: begin
                if (item.prefer_new_bucket && !item.allow_new_bucket) begin
                  res_q_next.status = bsa_pkg::ST_BAD_FLAGS;
                  state_next        = S_DONE;
                end else if (live[8]) begin
                  res_q_next.status = bsa_pkg::ST_FULL;
                  state_next        = S_DONE;
                end else begin
                  last_addr_next = {used_m1, cap_m1};
                  wrap_next      = cap_m1;
                  go_next        = !item.prefer_new_bucket && (used != 5'd0);
                  state_next     = S_ADD_SCAN;
                end
              end
              bsa_pkg::ACT_REMOVE, bsa_pkg::ACT_LOCATE: begin
                state_next = S_FIND;
              end
              default: begin
                res_q_next.status = bsa_pkg::ST_BAD_FLAGS;
                state_next        = S_DONE;
              end
            endcase
          end
        end
      end

      S_ADD_SCAN, S_ADD_OPEN: begin
        if (rd_v && t_rdata == bsa_pkg::MARK_EMPTY) begin
          tgt_b_next = rd_a[7:4];
          tgt_s_next = rd_a[3:0];
          go_next    = 1'b0;
          state_next = S_ADD_WRITE;
        end else if (!go && !rd_v) begin
          state_next = (state == S_ADD_SCAN) ? S_ADD_NEW : S_ADD_FRESH;
        end else if (go) begin
          t_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_ADD_NEW: begin
        if (!cur.allow_new_bucket) begin
          res_q_next.status = bsa_pkg::ST_NO_SLOT;
          state_next        = S_DONE;
        end else if (open_sel != 5'd0 && open_m1 < used) begin
          bkt_next       = open_m1[3:0];
          slt_next       = 4'd0;
          last_addr_next = {open_m1[3:0], cap_m1};
          wrap_next      = cap_m1;
          go_next        = 1'b1;
          state_next     = S_ADD_OPEN;
        end else begin
          state_next = S_ADD_FRESH;
        end
      end

      S_ADD_FRESH: begin
        if (used[4]) begin
          res_q_next.status = bsa_pkg::ST_FULL;
          state_next        = S_DONE;
        end else begin
          tgt_b_next    = used[3:0];
          tgt_s_next    = 4'd0;
          open_sel_next = used + 5'd1;
          used_next     = used + 5'd1;
          state_next    = S_ADD_WRITE;
        end
      end

      S_ADD_WRITE: begin
        t_we    = 1'b1;
        t_waddr = {tgt_b, tgt_s};
        t_wdata = {2'b00, live[7:0]};
        i_we    = 1'b1;
        i_waddr = live[7:0];
        i_wdata = cur.object_id;
        live_next    = live + 9'd1;
        occ_next     = occ + 9'd1;
        open_nb_next = open_sel;
        res_q_next.status        = bsa_pkg::ST_OK;
        res_q_next.placed_index  = live[7:0];
        res_q_next.placed_bucket = tgt_b;
        res_q_next.placed_slot   = tgt_s;
        state_next = S_DONE;
      end

      S_FIND: begin
        if (rd_v && t_rdata == {2'b00, cur.object_index}) begin
          tgt_b_next = rd_a[7:4];
          tgt_s_next = rd_a[3:0];
          res_q_next.placed_index  = cur.object_index;
          res_q_next.placed_bucket = rd_a[7:4];
          res_q_next.placed_slot   = rd_a[3:0];
          i_re       = 1'b1;
          i_raddr    = cur.object_index;
          go_next    = 1'b0;
          state_next = S_ID_WAIT;
        end else if (!go && !rd_v) begin
          state_next = S_DONE;
          if (cur.action == bsa_pkg::ACT_LOCATE || cur.strict_remove) begin
            res_q_next.status = bsa_pkg::ST_NOT_FOUND;
          end else if (used == 5'd0) begin
            // remove on an empty table poisons it
            ok_next      = 1'b0;
            used_next    = '0;
            live_next    = '0;
            occ_next     = '0;
            open_nb_next = '0;
          end
        end else if (go) begin
          t_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_ID_WAIT: begin
        res_q_next.found_id = i_rdata;
        if (cur.action == bsa_pkg::ACT_LOCATE) begin
          state_next = S_DONE;
        end else begin
          t_we           = 1'b1;
          t_waddr        = {tgt_b, tgt_s};
          t_wdata        = bsa_pkg::MARK_REMOVED;
          bkt_next       = tgt_b;
          slt_next       = 4'd0;
          last_addr_next = {tgt_b, SLT_LAST};
          wrap_next      = SLT_LAST;
          go_next        = 1'b1;
          live_seen_next = 1'b0;
          used_cnt_next  = '0;
          state_next     = S_LIVE;
        end
      end

      S_LIVE: begin
        if (rd_v) begin
          if (t_rdata < bsa_pkg::MARK_REMOVED) live_seen_next = 1'b1;
          if (t_rdata != bsa_pkg::MARK_EMPTY) used_cnt_next = used_cnt + 5'd1;
        end
        if (!go && !rd_v) begin
          if (live_seen) begin
            state_next = S_POST;
          end else begin
            res_q_next.bucket_dropped = 1'b1;
            res_q_next.dropped_bucket = tgt_b;
            occ_next = (occ >= {4'd0, used_cnt}) ? occ - {4'd0, used_cnt} : 9'd0;
            if (open_nb != 5'd0) begin
              if (onb_m1 == {1'b0, tgt_b}) begin
                open_nb_next = 5'd0;
              end else if (onb_m1 > {1'b0, tgt_b}) begin
                open_nb_next = onb_m1;
              end
            end
            slt_next       = 4'd0;
            last_addr_next = {used_m1, SLT_LAST};
            wrap_next      = SLT_LAST;
            go_next        = 1'b1;
            if ({1'b0, tgt_b} + 5'd1 < used) begin
              bkt_next   = tgt_b + 4'd1;
              state_next = S_COPY;
            end else begin
              bkt_next   = used_m1;
              state_next = S_WIPE;
            end
          end
        end else if (go) begin
          t_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_COPY: begin
        // move every later bucket down by one
        if (rd_v) begin
          t_we    = 1'b1;
          t_waddr = {rd_a[7:4] - 4'd1, rd_a[3:0]};
          t_wdata = t_rdata;
        end
        if (!go && !rd_v) begin
          bkt_next       = used_m1;
          slt_next       = 4'd0;
          last_addr_next = {used_m1, SLT_LAST};
          go_next        = 1'b1;
          state_next     = S_WIPE;
        end else if (go) begin
          t_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_WIPE: begin
        t_we = 1'b1;
        if (at_last) begin
          used_next  = used - 5'd1;
          go_next    = 1'b0;
          state_next = S_POST;
        end else begin
          bkt_next = step_bkt;
          slt_next = step_slt;
        end
      end

      S_POST: begin
        if (used == 5'd0) begin
          ok_next      = 1'b0;
          live_next    = '0;
          occ_next     = '0;
          open_nb_next = '0;
          state_next   = S_DONE;
        end else begin
          bkt_next       = 4'd0;
          slt_next       = 4'd0;
          last_addr_next = {used_m1, SLT_LAST};
          wrap_next      = SLT_LAST;
          go_next        = 1'b1;
          state_next     = S_DEC;
        end
      end

      S_DEC: begin
        // renumber objects above the removed one
        if (rd_v) begin
          t_we    = 1'b1;
          t_waddr = rd_a;
          if (t_rdata < bsa_pkg::MARK_REMOVED && t_rdata > {2'b00, cur.object_index}) begin
            t_wdata = t_rdata - 10'd1;
          end else begin
            t_wdata = t_rdata;
          end
        end
        if (!go && !rd_v) begin
          if (idx_p1 < live) begin
            bkt_next       = idx_p1[7:4];
            slt_next       = idx_p1[3:0];
            last_addr_next = live_m1[7:0];
            wrap_next      = SLT_LAST;
            go_next        = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            live_next  = live_m1;
            state_next = S_DONE;
          end
        end else if (go) begin
          t_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_SHIFT: begin
        // close up the id store
        if (rd_v) begin
          i_we    = 1'b1;
          i_waddr = rd_a - 8'd1;
          i_wdata = i_rdata;
        end
        if (!go && !rd_v) begin
          live_next  = live_m1;
          state_next = S_DONE;
        end else if (go) begin
          i_re      = 1'b1;
          rd_v_next = 1'b1;
          if (at_last) begin
            go_next = 1'b0;
          end else begin
            bkt_next = step_bkt;
            slt_next = step_slt;
          end
        end
      end

      S_DONE: begin
        if (take) state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      bkt       <= 4'd0;
      slt       <= 4'd0;
      wrap      <= SLT_LAST;
      last_addr <= 8'hFF;
      go        <= 1'b1;
      rd_v      <= 1'b0;
      used      <= '0;
      live      <= '0;
      occ       <= '0;
      ok        <= 1'b1;
      open_nb   <= '0;
    end else begin
      state     <= state_next;
      bkt       <= bkt_next;
      slt       <= slt_next;
      wrap      <= wrap_next;
      last_addr <= last_addr_next;
      go        <= go_next;
      rd_v      <= rd_v_next;
      used      <= used_next;
      live      <= live_next;
      occ       <= occ_next;
      ok        <= ok_next;
      open_nb   <= open_nb_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_a      <= rd_a_next;
    open_sel  <= open_sel_next;
    cur       <= cur_next;
    res_q     <= res_q_next;
    tgt_b     <= tgt_b_next;
    tgt_s     <= tgt_s_next;
    live_seen <= live_seen_next;
    used_cnt  <= used_cnt_next;
  end

  assign prod  = 10'(used) * 10'(cap);
  assign ready = (state == S_IDLE);
  assign done  = (state == S_DONE);

  always_comb begin
    res              = res_q;
    res.free_slots   = (prod > {1'b0, occ}) ? 9'(prod - {1'b0, occ}) : 9'd0;
    res.object_total = live;
    res.bucket_total = used;
    res.table_valid  = ok;
  end

endmodule

// ----- rtl/core/bucket_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bucket_slot_allocator_unit
// bucket and slot allocator for densely numbered objects
// ----------------------------------------------------------------------------
// one item is worked at a time by a sequencer that walks a 256-entry slot
// table through a single address walker, one slot read per cycle. after
// reset the table is swept to empty while item_stall is held high. an add
// that finds a free slot scans up to buckets in use times capacity slots.
// an add that has to open a fresh bucket scans as many, and when an open
// bucket is tried first at most capacity more slots. locate scans the slots
// until the object is found (up to 256).
// a remove walks the table several times: find (up to 256), a 16-slot check
// of its bucket, and when the bucket empties a close-up copy of the later
// buckets (up to 240) and a wipe of the last bucket, then a renumbering pass
// over all buckets in use (up to 256) and an id store shift (up to 255). a
// finished result sits in an output register so the next item can be taken
// while the result still waits for its transfer.
// the capacity register is written over its own valid/ready port.
module bucket_slot_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bsa_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output bsa_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);

  logic             eng_ready;
  logic             eng_done;
  logic             take;
  logic             start;
  logic [4:0]       capacity;
  bsa_pkg::result_t eng_res;

  // capacity register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // input transfer only when the sequencer is idle
  assign item_stall = !eng_ready;
  assign start      = item_valid && !item_stall;

  // result moves into the output register when it is free or draining
  assign take = eng_done && (!result_valid || !result_stall);

  bsa_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .cap   (bsa_pkg::eff_cap(capacity)),
    .take  (take),
    .ready (eng_ready),
    .done  (eng_done),
    .res   (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= eng_res;
    end
  end

endmodule

// ----- rtl/core/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// port level checks of the bucket slot allocator
// ----------------------------------------------------------------------------
`include "bucket_slot_allocator_unit_assert.svh"

module bsa_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input bsa_pkg::result_t result
);

  // a held result keeps its contents
  `BSA_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

  // an accepted item keeps the block busy in the next cycle
  `BSA_ASSERT_NEXT(a_busy, item_valid && !item_stall, item_stall, "input taken twice in a row")

  // an invalid table holds no objects and no buckets
  `BSA_ASSERT_NOW(a_inval, result_valid && !result.table_valid, result.object_total == 9'd0 && result.bucket_total == 5'd0, "invalid table not empty")

  // errors carry no place or id
  `BSA_ASSERT_NOW(a_err, result_valid && result.status != bsa_pkg::ST_OK, result.found_id == 32'd0 && !result.bucket_dropped && result.placed_index == 8'd0, "error result with payload")

  // no bucket means no free slot
  `BSA_ASSERT_NOW(a_free, result_valid && result.bucket_total == 5'd0, result.free_slots == 9'd0, "free slots without buckets")

endmodule

bind bucket_slot_allocator_unit bsa_checker u_bsa_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bucket slot allocator: a predictor of the slot
// table tracks every accepted item, and a checker compares each result
// transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 1200;   // longest remove plus margin
  localparam int TOTAL_SLOTS = bsa_pkg::NUM_BUCKETS * bsa_pkg::NUM_SLOTS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  bsa_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bsa_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  bucket_slot_allocator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the allocator state
  logic [9:0]  shadow_slots [TOTAL_SLOTS];
  logic [31:0] shadow_ids [256];
  int unsigned shadow_buckets, shadow_objects, shadow_occupied, shadow_open;
  logic        shadow_ok;
  logic [4:0]  shadow_cap;

  bsa_pkg::result_t expected_results [$];
  logic [2:0] last_status;
  int errors = 0;
  int cycles = 0;

  // idling knobs, in percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  function automatic int unsigned usable_cap();
    if (shadow_cap == 5'd0) return 1;
    if (shadow_cap > 5'd16) return bsa_pkg::NUM_SLOTS;
    return shadow_cap;
  endfunction

  function automatic int first_empty(int unsigned b);
    for (int s = 0; s < usable_cap(); s++)
      if (shadow_slots[b * bsa_pkg::NUM_SLOTS + s] == bsa_pkg::MARK_EMPTY) return s;
    return -1;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < TOTAL_SLOTS; i++) shadow_slots[i] = bsa_pkg::MARK_EMPTY;
    for (int i = 0; i < 256; i++) shadow_ids[i] = '0;
    shadow_buckets = 0;
    shadow_objects = 0;
    shadow_occupied = 0;
    shadow_open = 0;
  endtask

  task automatic predict_add(input bsa_pkg::item_t it, inout bsa_pkg::result_t r);
    int unsigned open_b, b, s, n;
    int fs;
    logic hit;
    open_b = it.batch_start ? 0 : shadow_open;
    hit = 1'b0;
    b = 0;
    s = 0;
    if (it.prefer_new_bucket && !it.allow_new_bucket) begin
      r.status = bsa_pkg::ST_BAD_FLAGS;
      return;
    end
    if (shadow_objects >= 256) begin
      r.status = bsa_pkg::ST_FULL;
      return;
    end
    if (!it.prefer_new_bucket) begin
      for (int unsigned k = 0; k < shadow_buckets && !hit; k++) begin
        fs = first_empty(k);
        if (fs >= 0) begin
          b = k;
          s = fs;
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      if (!it.allow_new_bucket) begin
        r.status = bsa_pkg::ST_NO_SLOT;
        return;
      end
      fs = (open_b != 0 && open_b - 1 < shadow_buckets) ? first_empty(open_b - 1) : -1;
      if (fs >= 0) begin
        b = open_b - 1;
        s = fs;
      end else begin
        if (shadow_buckets >= bsa_pkg::NUM_BUCKETS) begin
          r.status = bsa_pkg::ST_FULL;
          return;
        end
        b = shadow_buckets++;
        for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++)
          shadow_slots[b * bsa_pkg::NUM_SLOTS + i] = bsa_pkg::MARK_EMPTY;
        s = 0;
        open_b = b + 1;
      end
    end
    n = shadow_objects;
    shadow_slots[b * bsa_pkg::NUM_SLOTS + s] = 10'(n);
    shadow_ids[n] = it.object_id;
    shadow_objects++;
    shadow_occupied++;
    shadow_open = open_b;
    r.placed_index = 8'(n);
    r.placed_bucket = 4'(b);
    r.placed_slot = 4'(s);
  endtask

  function automatic logic find_place(int unsigned idx, output int unsigned b,
                                      output int unsigned s);
    b = 0;
    s = 0;
    for (int unsigned k = 0; k < shadow_buckets; k++)
      for (int unsigned j = 0; j < bsa_pkg::NUM_SLOTS; j++)
        if (shadow_slots[k * bsa_pkg::NUM_SLOTS + j] == 10'(idx)) begin
          b = k;
          s = j;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  task automatic predict_remove(input bsa_pkg::item_t it, inout bsa_pkg::result_t r);
    int unsigned idx, b, s, used;
    logic live;
    idx = it.object_index;
    if (!find_place(idx, b, s)) begin
      if (it.strict_remove) begin
        r.status = bsa_pkg::ST_NOT_FOUND;
        return;
      end
      // unknown object on a table with no bucket kills the table
      if (shadow_buckets == 0) begin
        wipe_table();
        shadow_ok = 1'b0;
      end
      return;
    end
    r.placed_index = 8'(idx);
    r.placed_bucket = 4'(b);
    r.placed_slot = 4'(s);
    r.found_id = shadow_ids[idx];
    shadow_slots[b * bsa_pkg::NUM_SLOTS + s] = bsa_pkg::MARK_REMOVED;
    live = 1'b0;
    for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++)
      if (shadow_slots[b * bsa_pkg::NUM_SLOTS + i] < bsa_pkg::MARK_REMOVED) live = 1'b1;
    if (!live) begin
      used = 0;
      for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++)
        if (shadow_slots[b * bsa_pkg::NUM_SLOTS + i] != bsa_pkg::MARK_EMPTY) used++;
      for (int unsigned k = b; k + 1 < shadow_buckets; k++)
        for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++)
          shadow_slots[k * bsa_pkg::NUM_SLOTS + i] =
            shadow_slots[(k + 1) * bsa_pkg::NUM_SLOTS + i];
      shadow_buckets--;
      for (int i = 0; i < bsa_pkg::NUM_SLOTS; i++)
        shadow_slots[shadow_buckets * bsa_pkg::NUM_SLOTS + i] = bsa_pkg::MARK_EMPTY;
      shadow_occupied = (shadow_occupied >= used) ? shadow_occupied - used : 0;
      if (shadow_open != 0) begin
        if (shadow_open - 1 == b) shadow_open = 0;
        else if (shadow_open - 1 > b) shadow_open--;
      end
      r.bucket_dropped = 1'b1;
      r.dropped_bucket = 4'(b);
    end
    if (shadow_buckets == 0) begin
      wipe_table();
      shadow_ok = 1'b0;
      return;
    end
    // close up the numbering above the removed object
    for (int unsigned i = 0; i < shadow_buckets * bsa_pkg::NUM_SLOTS; i++)
      if (shadow_slots[i] < bsa_pkg::MARK_REMOVED && shadow_slots[i] > 10'(idx))
        shadow_slots[i] = shadow_slots[i] - 10'd1;
    for (int unsigned k = idx; k + 1 < shadow_objects; k++) shadow_ids[k] = shadow_ids[k + 1];
    if (shadow_objects > 0) shadow_objects--;
  endtask

  task automatic predict_outcome(input bsa_pkg::item_t it, output bsa_pkg::result_t r);
    int unsigned b, s, total;
    r = '0;
    if (!shadow_ok) r.status = bsa_pkg::ST_INVALID;
    else begin
      case (it.action)
        bsa_pkg::ACT_ADD: predict_add(it, r);
        bsa_pkg::ACT_REMOVE: predict_remove(it, r);
        bsa_pkg::ACT_LOCATE: begin
          if (find_place(it.object_index, b, s)) begin
            r.placed_index = it.object_index;
            r.placed_bucket = 4'(b);
            r.placed_slot = 4'(s);
            r.found_id = shadow_ids[it.object_index];
          end else r.status = bsa_pkg::ST_NOT_FOUND;
        end
        default: r.status = bsa_pkg::ST_BAD_FLAGS;
      endcase
    end
    if (r.status != bsa_pkg::ST_OK) r = '{status: r.status, default: '0};
    total = shadow_buckets * usable_cap();
    r.free_slots = 9'((total > shadow_occupied) ? total - shadow_occupied : 0);
    r.object_total = 9'(shadow_objects);
    r.bucket_total = 5'(shadow_buckets);
    r.table_valid = shadow_ok;
  endtask

  // receiver: random stall, or a one-shot long hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 4000;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t mismatch %s expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  // result checker: one comparison per transfer
  always @(posedge clk) begin
    bsa_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transfer, expected none actual %h", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) report("status", want.status, result.status);
        if (result.placed_index !== want.placed_index)
          report("placed_index", want.placed_index, result.placed_index);
        if (result.placed_bucket !== want.placed_bucket)
          report("placed_bucket", want.placed_bucket, result.placed_bucket);
        if (result.placed_slot !== want.placed_slot)
          report("placed_slot", want.placed_slot, result.placed_slot);
        if (result.found_id !== want.found_id) report("found_id", want.found_id, result.found_id);
        if (result.bucket_dropped !== want.bucket_dropped)
          report("bucket_dropped", want.bucket_dropped, result.bucket_dropped);
        if (result.dropped_bucket !== want.dropped_bucket)
          report("dropped_bucket", want.dropped_bucket, result.dropped_bucket);
        if (result.free_slots !== want.free_slots)
          report("free_slots", want.free_slots, result.free_slots);
        if (result.object_total !== want.object_total)
          report("object_total", want.object_total, result.object_total);
        if (result.bucket_total !== want.bucket_total)
          report("bucket_total", want.bucket_total, result.bucket_total);
        if (result.table_valid !== want.table_valid)
          report("table_valid", want.table_valid, result.table_valid);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // one item transfer; valid stays high so a following item goes back to back
  task automatic send_item(input bsa_pkg::item_t it);
    bsa_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_outcome(it, r);
    expected_results = {expected_results, r};
    last_status = r.status;
  endtask

  task automatic pause_sender();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    pause_sender();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_cap = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic bsa_pkg::item_t make_item(input logic [1:0] act, input int unsigned idx,
                                               input logic allow, input logic prefer,
                                               input logic batch, input logic strict);
    bsa_pkg::item_t it;
    it.action = act;
    it.object_index = 8'(idx);
    it.object_id = $urandom();
    it.allow_new_bucket = allow;
    it.prefer_new_bucket = prefer;
    it.batch_start = batch;
    it.strict_remove = strict;
    return it;
  endfunction

  // remove of a live object picked at random
  function automatic bsa_pkg::item_t live_remove();
    return make_item(bsa_pkg::ACT_REMOVE, $urandom_range(shadow_objects - 1), 1'($urandom()),
                     1'($urandom()), 1'($urandom()), 1'($urandom()));
  endfunction

  function automatic bsa_pkg::item_t random_item();
    int unsigned pick;
    logic [1:0] act;
    pick = $urandom_range(99);
    if (shadow_objects > 200 && pick < 45) pick = 50;
    if (pick < 45) begin
      // mostly well-formed adds
      act = bsa_pkg::ACT_ADD;
      if ($urandom_range(9) == 0)
        return make_item(act, $urandom_range(255), 1'($urandom()), 1'($urandom()),
                         1'($urandom()), 1'($urandom()));
      return make_item(act, $urandom_range(255), 1'b1, $urandom_range(3) == 0,
                       $urandom_range(4) == 0, 1'($urandom()));
    end
    if (pick < 80 && shadow_objects >= 2) return live_remove();
    if (pick < 95 && shadow_objects >= 1)
      return make_item(bsa_pkg::ACT_LOCATE, $urandom_range(shadow_objects - 1),
                       1'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
    // noise: unknown objects and the unused action
    if (shadow_objects >= 1 && shadow_objects < 256 && $urandom_range(2) != 0)
      return make_item($urandom_range(1) ? bsa_pkg::ACT_REMOVE : bsa_pkg::ACT_LOCATE,
                       $urandom_range(255, shadow_objects), 1'($urandom()), 1'($urandom()),
                       1'($urandom()), 1'($urandom()));
    return make_item(ACT_UNUSED, $urandom_range(255), 1'($urandom()), 1'($urandom()),
                     1'($urandom()), 1'($urandom()));
  endfunction

  task automatic test_directed();
    bsa_pkg::item_t it;
    send_item(make_item(bsa_pkg::ACT_LOCATE, 0, 0, 0, 0, 0));   // empty table
    send_item(make_item(bsa_pkg::ACT_REMOVE, 255, 1, 1, 1, 1)); // strict remove, unknown
    send_item(make_item(ACT_UNUSED, 255, 1, 1, 1, 1));
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 0, 1, 0, 0));      // prefer without allow
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 0, 0, 0, 0));      // no slot, no new bucket
    it = make_item(bsa_pkg::ACT_ADD, 255, 1, 0, 1, 1);
    it.object_id = '1;
    send_item(it);
    it = make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0);
    it.object_id = '0;
    send_item(it);
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 1, 1, 0));      // fresh new bucket
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 1, 0, 0));      // continue open bucket
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0));      // first free slot
    send_item(make_item(bsa_pkg::ACT_LOCATE, 0, 0, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_LOCATE, 2, 0, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_LOCATE, 255, 0, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_REMOVE, 200, 0, 0, 0, 0)); // lenient remove, unknown
    send_item(make_item(bsa_pkg::ACT_REMOVE, 1, 0, 0, 0, 1));   // middle object, close up
    send_item(make_item(bsa_pkg::ACT_LOCATE, 1, 0, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_REMOVE, 1, 0, 0, 0, 1));   // second bucket keeps one
    send_item(make_item(bsa_pkg::ACT_REMOVE, 1, 0, 0, 0, 1));   // empties the second bucket
    send_item(make_item(bsa_pkg::ACT_LOCATE, 1, 0, 0, 0, 0));
    pause_sender();
  endtask

  task automatic test_capacity();
    // zero reads as one slot per bucket: buckets run out fast
    write_capacity(5'd0);
    for (int i = 0; i < 18; i++) send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_item(live_remove());
    write_capacity(5'd31);
    for (int i = 0; i < 10; i++) send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0));
    // lowering capacity below occupancy saturates free_slots
    write_capacity(5'd1);
    send_item(make_item(bsa_pkg::ACT_LOCATE, 0, 0, 0, 0, 0));
    pause_sender();
  endtask

  task automatic test_fill();
    write_capacity(5'd8);
    for (int i = 0; i < 300; i++) begin
      send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0));
      if (last_status != bsa_pkg::ST_OK) break;
    end
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 1, 1, 0));
    while (shadow_objects > 24) send_item(live_remove());
    pause_sender();
  endtask

  task automatic test_random_phases();
    int idle [4] = '{0, 60, 0, 30};
    int stall [4] = '{0, 0, 60, 30};
    logic [4:0] caps [4] = '{5'd16, 5'd1, 5'd3, 5'd7};
    for (int p = 0; p < 4; p++) begin
      write_capacity((p == 3) ? 5'($urandom_range(31)) : caps[p]);
      send_idle_pct = idle[p];
      recv_stall_pct = stall[p];
      for (int i = 0; i < 60; i++) send_item(random_item());
      pause_sender();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_go = 1'b1;
    for (int i = 0; i < 30; i++) send_item(random_item());
    pause_sender();
  endtask

  task automatic test_invalidate();
    wait_drained();
    recv_stall_pct = 30;
    while (shadow_objects > 0) send_item(make_item(bsa_pkg::ACT_REMOVE, 0, 0, 0, 0, 1));
    send_item(make_item(bsa_pkg::ACT_ADD, 0, 1, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_LOCATE, 0, 0, 0, 0, 0));
    send_item(make_item(bsa_pkg::ACT_REMOVE, 0, 0, 0, 0, 0));
    pause_sender();
  endtask

  initial begin
    wipe_table();
    shadow_ok = 1'b1;
    shadow_cap = 5'd16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    test_fill();
    test_random_phases();
    test_backpressure();
    test_invalidate();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bsa_pkg.sv
rtl/core/bsa_ram.sv
rtl/core/bsa_engine.sv
rtl/core/bucket_slot_allocator_unit.sv
rtl/core/bsa_checker.sv
tb/sv/testbench.sv
